// ===== hdl/fdrm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fdrm_pkg
// Shared widths, constants and event codes of the frame and drop rate meter.
// ============================================================================
package fdrm_pkg;

    // Ring depth and the widths of the fields.
    localparam int WINDOW    = 16;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int TS_W      = 32;
    localparam int TICKS_W   = 20;
    localparam int RATE_W    = 32;
    localparam int FRAC_BITS = 8;
    localparam int MS_PER_S  = 1000;

    // The numerator is ticks_per_ms times this scale.
    localparam longint SCALE   = longint'(WINDOW) * MS_PER_S * (longint'(1) << FRAC_BITS);
    localparam int     SCALE_W = $clog2(SCALE + 1);
    localparam int     NUM_W   = TICKS_W + SCALE_W;
    localparam int     CNT_W   = $clog2(NUM_W);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [SCALE_W-1:0] SCALE_K  = SCALE_W'(SCALE);

    // Event kinds carried on s_tuser.
    localparam logic OP_SENT    = 1'b0;
    localparam logic OP_DROPPED = 1'b1;

    // Quotient pass selector.
    localparam logic PASS_SENT    = 1'b0;
    localparam logic PASS_DROPPED = 1'b1;

endpackage

// ===== hdl/frame_and_drop_rate_meter_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// frame_and_drop_rate_meter_core
// Sliding-window rate meter for sent and dropped frames.
// ============================================================================
// Usage:
// The s_ channel carries one frame event per request: s_tdata is the 32-bit
// timestamp, s_tuser is the kind (0 sent, 1 dropped). The m_ channel returns
// one result per event: m_tdata[31:0] is the sent rate and m_tdata[63:32] the
// dropped rate, both frames per second in unsigned 24.8 fixed point.
// The cfg_ channel writes ticks_per_ms (20 bits, reset value 1) and is always
// ready. Write it only while the block is idle; the block does not check this.
// Each event passes from acceptance to m_tvalid through a load step, then two
// passes of a shared restoring divider that retires one quotient bit per cycle
// over the 42-bit numerator, then an output step. A pass whose interval is not
// positive skips the divider and gives a zero rate. s_tready rises together
// with m_tvalid, so the next event can be accepted once the result is raised.
// s_tready is high only while no event is in progress. A finished result sits
// in the output register; if the receiver stalls, the next event may still be
// accepted and processed, and it waits in its output step until the register
// is free. Reset clears the ring valid bits, slots, latest time and m_tvalid.
// ============================================================================
module frame_and_drop_rate_meter_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Event input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] timestamp
    input  logic        s_tuser,   // [0] op
    // Rate output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] sent_rate, [63:32] dropped_rate
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data   // [19:0] ticks_per_ms
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_PREP = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [fdrm_pkg::TS_W-1:0]    sent_ring_reg [fdrm_pkg::WINDOW];
    logic [fdrm_pkg::TS_W-1:0]    drop_ring_reg [fdrm_pkg::WINDOW];
    logic [fdrm_pkg::WINDOW-1:0]  sent_vld_reg, sent_vld_next;
    logic [fdrm_pkg::WINDOW-1:0]  drop_vld_reg, drop_vld_next;
    logic [fdrm_pkg::SLOT_W-1:0]  sent_slot_reg, sent_slot_next;
    logic [fdrm_pkg::SLOT_W-1:0]  drop_slot_reg, drop_slot_next;
    logic [fdrm_pkg::TS_W-1:0]    latest_reg, latest_next;
    logic [fdrm_pkg::TICKS_W-1:0] ticks_reg, ticks_next;

    logic [fdrm_pkg::TS_W-1:0]    old_sent_reg, old_sent_next;
    logic [fdrm_pkg::TS_W-1:0]    old_drop_reg, old_drop_next;
    logic [fdrm_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [fdrm_pkg::NUM_W-1:0]   quo_reg, quo_next;
    logic [fdrm_pkg::TS_W-1:0]    rem_reg, rem_next;
    logic [fdrm_pkg::TS_W-1:0]    span_reg, span_next;
    logic [fdrm_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         pass_reg, pass_next;
    logic [fdrm_pkg::RATE_W-1:0]  sent_rate_reg, sent_rate_next;
    logic [fdrm_pkg::RATE_W-1:0]  drop_rate_reg, drop_rate_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [63:0]                  m_tdata_reg, m_tdata_next;

    logic                         in_fire;
    logic                         wr_sent;
    logic                         wr_drop;
    logic [fdrm_pkg::TS_W-1:0]    oldest;
    logic [fdrm_pkg::TS_W:0]      trial;
    logic [fdrm_pkg::TS_W:0]      diff;
    logic                         qbit;
    logic [fdrm_pkg::RATE_W-1:0]  quo_rate;
    logic [fdrm_pkg::RATE_W-1:0]  pass_rate;
    logic                         pass_done;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_fire = s_tvalid && s_tready;
    assign wr_sent = in_fire && (s_tuser == fdrm_pkg::OP_SENT);
    assign wr_drop = in_fire && (s_tuser == fdrm_pkg::OP_DROPPED);

    assign oldest = (pass_reg == fdrm_pkg::PASS_DROPPED) ? old_drop_reg : old_sent_reg;

    // One restoring step: bring down the next numerator bit and try the span.
    assign trial = {rem_reg, quo_reg[fdrm_pkg::NUM_W-1]};
    assign diff  = trial - {1'b0, span_reg};
    assign qbit  = (trial >= {1'b0, span_reg});

    // Any quotient bit above the output width means saturation.
    assign quo_rate = (|quo_reg[fdrm_pkg::NUM_W-1:fdrm_pkg::RATE_W]) ?
                      {fdrm_pkg::RATE_W{1'b1}} : quo_reg[fdrm_pkg::RATE_W-1:0];

    always_comb begin
        state_next     = state_reg;
        sent_vld_next  = sent_vld_reg;
        drop_vld_next  = drop_vld_reg;
        sent_slot_next = sent_slot_reg;
        drop_slot_next = drop_slot_reg;
        latest_next    = latest_reg;
        ticks_next     = ticks_reg;
        old_sent_next  = old_sent_reg;
        old_drop_next  = old_drop_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        span_next      = span_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        sent_rate_next = sent_rate_reg;
        drop_rate_next = drop_rate_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        pass_rate      = '0;
        pass_done      = 1'b0;

        if (cfg_valid && cfg_ready) begin
            ticks_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    latest_next = s_tdata;
                    if (wr_sent) begin
                        sent_vld_next[sent_slot_reg] = 1'b1;
                        sent_slot_next = (sent_slot_reg == fdrm_pkg::LAST_SLOT) ?
                                         '0 : sent_slot_reg + 1'b1;
                    end else begin
                        drop_vld_next[drop_slot_reg] = 1'b1;
                        drop_slot_next = (drop_slot_reg == fdrm_pkg::LAST_SLOT) ?
                                         '0 : drop_slot_reg + 1'b1;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // Entries never written read as the cleared stamp zero.
                old_sent_next = sent_vld_reg[sent_slot_reg] ? sent_ring_reg[sent_slot_reg] : '0;
                old_drop_next = drop_vld_reg[drop_slot_reg] ? drop_ring_reg[drop_slot_reg] : '0;
                num_next      = fdrm_pkg::NUM_W'(ticks_reg) * fdrm_pkg::NUM_W'(fdrm_pkg::SCALE_K);
                pass_next     = fdrm_pkg::PASS_SENT;
                state_next    = ST_PREP;
            end
            ST_PREP: begin
                if (latest_reg > oldest) begin
                    span_next  = latest_reg - oldest;
                    rem_next   = '0;
                    quo_next   = num_reg;
                    cnt_next   = fdrm_pkg::CNT_W'(fdrm_pkg::NUM_W - 1);
                    state_next = ST_DIV;
                end else begin
                    pass_rate = '0;
                    pass_done = 1'b1;
                end
            end
            ST_DIV: begin
                rem_next = qbit ? diff[fdrm_pkg::TS_W-1:0] : trial[fdrm_pkg::TS_W-1:0];
                quo_next = {quo_reg[fdrm_pkg::NUM_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                pass_rate = quo_rate;
                pass_done = 1'b1;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {drop_rate_reg, sent_rate_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished pass stores its rate and starts the next pass or output.
        if (pass_done) begin
            if (pass_reg == fdrm_pkg::PASS_SENT) begin
                sent_rate_next = pass_rate;
                pass_next      = fdrm_pkg::PASS_DROPPED;
                state_next     = ST_PREP;
            end else begin
                drop_rate_next = pass_rate;
                state_next     = ST_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sent_vld_reg  <= '0;
            drop_vld_reg  <= '0;
            sent_slot_reg <= '0;
            drop_slot_reg <= '0;
            latest_reg    <= '0;
            ticks_reg     <= fdrm_pkg::TICKS_W'(1);
            m_tvalid_reg  <= 1'b0;
            pass_reg      <= fdrm_pkg::PASS_SENT;
        end else begin
            state_reg     <= state_next;
            sent_vld_reg  <= sent_vld_next;
            drop_vld_reg  <= drop_vld_next;
            sent_slot_reg <= sent_slot_next;
            drop_slot_reg <= drop_slot_next;
            latest_reg    <= latest_next;
            ticks_reg     <= ticks_next;
            m_tvalid_reg  <= m_tvalid_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_sent_reg  <= old_sent_next;
        old_drop_reg  <= old_drop_next;
        num_reg       <= num_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        span_reg      <= span_next;
        cnt_reg       <= cnt_next;
        sent_rate_reg <= sent_rate_next;
        drop_rate_reg <= drop_rate_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // Timestamp rings; the valid bits stand in for the reset clear.
    always_ff @(posedge aclk) begin
        if (wr_sent) begin
            sent_ring_reg[sent_slot_reg] <= s_tdata;
        end
        if (wr_drop) begin
            drop_ring_reg[drop_slot_reg] <= s_tdata;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("event accepted while a previous event was in progress");

    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below the interval");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= fdrm_pkg::CNT_W'(fdrm_pkg::NUM_W - 1)))
        else $error("divider step count out of range");
`endif

endmodule
